@@ rtl/core/arsd_pkg.sv @@
package arsd_pkg;

	// stream words
	localparam int unsigned IN_W    = 48;
	localparam int unsigned OUT_W   = 40;

	// result word bit positions
	localparam int unsigned OB_STEP_LO  = 0;
	localparam int unsigned OB_REV_LO   = 16;
	localparam int unsigned OB_MOTION   = 33;
	localparam int unsigned OB_REVERSAL = 34;
	localparam int unsigned OB_STEP     = 35;
	localparam int unsigned OB_LOADED   = 36;
	localparam int unsigned OB_HELD     = 37;

	// datapath widths
	localparam int unsigned AX_W      = 17;
	localparam int unsigned MAG_W     = 16;
	localparam int unsigned SQ_W      = 34;
	localparam int unsigned DOT_MAG_W = 35;
	localparam int unsigned D2_W      = 68;
	localparam int unsigned MAC_W     = 88;
	localparam int unsigned OPX_W     = 68;
	localparam int unsigned OPY_W     = 36;
	localparam int unsigned DIG_W     = 4;
	localparam int unsigned CNT_W     = 17;
	localparam int unsigned KQ_SHIFT  = 32;

	// cos^2(90.5 deg) in unsigned Q0.32
	localparam logic [OPY_W-1:0] KQ_Y    = OPY_W'(327072);
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// apb
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// register reset values
	localparam logic [15:0] MOTION_THR_RST = 16'd45;
	localparam logic [15:0] PROJ_THR_RST   = 16'd25;
	localparam logic [15:0] MOTION_HO_RST  = 16'd10;
	localparam logic [15:0] REV_HO_RST     = 16'd20;

	typedef enum logic [2:0] {
		REG_OFFSET_X  = 3'd0,
		REG_OFFSET_Y  = 3'd1,
		REG_OFFSET_Z  = 3'd2,
		REG_MOTION_TH = 3'd3,
		REG_PROJ_TH   = 3'd4,
		REG_MOTION_HO = 3'd5,
		REG_REV_HO    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] offset_x;
		logic [15:0] offset_y;
		logic [15:0] offset_z;
		logic [15:0] motion_threshold;
		logic [15:0] projection_threshold;
		logic [15:0] motion_holdoff;
		logic [15:0] reversal_holdoff;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic             clear;
		logic             sub;
		logic [OPX_W-1:0] x;
		logic [OPY_W-1:0] y;
	} mac_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_DONE
	} state_t;

	// one code per product the sequencer asks for
	typedef enum logic [3:0] {
		OP_AX,
		OP_AY,
		OP_AZ,
		OP_MT,
		OP_DX,
		OP_DY,
		OP_DZ,
		OP_DD,
		OP_AR,
		OP_KQ,
		OP_PT,
		OP_PA
	} op_t;

	// magnitude of a corrected axis value, never beyond 65535
	function automatic logic [MAG_W-1:0] mag_of(input logic [AX_W-1:0] v);
		logic [AX_W-1:0] n;
		n = v[AX_W-1] ? (~v + AX_W'(1)) : v;
		return n[MAG_W-1:0];
	endfunction

endpackage

@@ rtl/core/arsd_cfg.sv @@
module arsd_cfg
	import arsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x             <= '0;
			cfg_q.offset_y             <= '0;
			cfg_q.offset_z             <= '0;
			cfg_q.motion_threshold     <= MOTION_THR_RST;
			cfg_q.projection_threshold <= PROJ_THR_RST;
			cfg_q.motion_holdoff       <= MOTION_HO_RST;
			cfg_q.reversal_holdoff     <= REV_HO_RST;
		end else if (wr_en) begin
			case (idx)
				REG_OFFSET_X:  cfg_q.offset_x             <= pwdata[15:0];
				REG_OFFSET_Y:  cfg_q.offset_y             <= pwdata[15:0];
				REG_OFFSET_Z:  cfg_q.offset_z             <= pwdata[15:0];
				REG_MOTION_TH: cfg_q.motion_threshold     <= pwdata[15:0];
				REG_PROJ_TH:   cfg_q.projection_threshold <= pwdata[15:0];
				REG_MOTION_HO: cfg_q.motion_holdoff       <= pwdata[15:0];
				REG_REV_HO:    cfg_q.reversal_holdoff     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux, offsets read back sign extended
	always_comb begin
		case (idx)
			REG_OFFSET_X:  prdata = {{16{cfg_q.offset_x[15]}}, cfg_q.offset_x};
			REG_OFFSET_Y:  prdata = {{16{cfg_q.offset_y[15]}}, cfg_q.offset_y};
			REG_OFFSET_Z:  prdata = {{16{cfg_q.offset_z[15]}}, cfg_q.offset_z};
			REG_MOTION_TH: prdata = {16'd0, cfg_q.motion_threshold};
			REG_PROJ_TH:   prdata = {16'd0, cfg_q.projection_threshold};
			REG_MOTION_HO: prdata = {16'd0, cfg_q.motion_holdoff};
			REG_REV_HO:    prdata = {16'd0, cfg_q.reversal_holdoff};
			default:       prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/arsd_mac.sv @@
module arsd_mac
	import arsd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  mac_cmd_t         cmd,
	output logic             busy,
	output logic [MAC_W-1:0] acc
);

	logic [MAC_W-1:0]       acc_q;
	logic [MAC_W-1:0]       x_q;
	logic [OPY_W-1:0]       y_q;
	logic                   sub_q;
	logic [MAC_W+DIG_W-1:0] prod;

	assign busy = (y_q != '0);
	assign acc  = acc_q;

	// one hex digit of the multiplier per cycle
	assign prod = {{DIG_W{1'b0}}, x_q} * {{MAC_W{1'b0}}, y_q[DIG_W-1:0]};

	// multiplier digits, the only control state here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q <= '0;
		end else if (cmd.start) begin
			y_q <= cmd.y;
		end else if (busy) begin
			y_q <= y_q >> DIG_W;
		end
	end

	// multiplicand shift and accumulate
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q   <= MAC_W'(cmd.x);
			sub_q <= cmd.sub;
			if (cmd.clear) begin
				acc_q <= '0;
			end
		end else if (busy) begin
			x_q   <= x_q << DIG_W;
			acc_q <= sub_q ? (acc_q - prod[MAC_W-1:0]) : (acc_q + prod[MAC_W-1:0]);
		end
	end

endmodule

@@ rtl/core/arsd_ctrl.sv @@
module arsd_ctrl
	import arsd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,
	output mac_cmd_t         mac_cmd,
	input  logic             mac_busy,
	input  logic [MAC_W-1:0] mac_acc
);

	state_t state_q, state_d;
	op_t    op_q, op_d;

	logic [AX_W-1:0]      a_q [3];
	logic [AX_W-1:0]      r_q [3];
	logic [AX_W-1:0]      a_in [3];
	logic [SQ_W-1:0]      a2_q, r2_q;
	logic [DOT_MAG_W-1:0] dmag_q;
	logic [D2_W-1:0]      d2_q;
	logic [OPX_W-1:0]     t_q;
	logic                 motion_q, loaded_q, rev_q, held_q;
	logic [CNT_W-1:0]     rcnt_q, rcnt_n;
	logic [CNT_W-1:0]     hold_q;
	logic                 m_valid_q;
	logic [OUT_W-1:0]     m_data_q;

	logic             s_fire, ev, out_free, done_fire;
	logic             hold_nz, motion_now, r_zero, dot_neg, angle_ok, proj_ok;
	logic             cnt_inc, step;
	logic [MAC_W-1:0] neg_acc;
	logic [CNT_W-1:0] hold_load;

	// corrected sample, wraps into 17 bits exactly
	assign a_in[0] = {s_axis_tdata[15], s_axis_tdata[15:0]}
		- {cfg.offset_x[15], cfg.offset_x};
	assign a_in[1] = {s_axis_tdata[31], s_axis_tdata[31:16]}
		- {cfg.offset_y[15], cfg.offset_y};
	assign a_in[2] = {s_axis_tdata[47], s_axis_tdata[47:32]}
		- {cfg.offset_z[15], cfg.offset_z};

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign ev            = (state_q == ST_WAIT) && !mac_busy;
	assign done_fire     = (state_q == ST_DONE) && out_free;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// decisions taken on finished products
	assign hold_nz    = (hold_q != '0);
	assign motion_now = a2_q > SQ_W'(mac_acc[2*MAG_W-1:0]);
	assign r_zero     = (r_q[0] == '0) && (r_q[1] == '0) && (r_q[2] == '0);
	assign dot_neg    = mac_acc[MAC_W-1];
	assign neg_acc    = ~mac_acc + MAC_W'(1);
	assign angle_ok   = d2_q > D2_W'(mac_acc[MAC_W-1:KQ_SHIFT]);
	assign proj_ok    = d2_q > mac_acc[D2_W-1:0];

	// counters at the end of an item
	assign cnt_inc   = rev_q && (rcnt_q != CNT_MAX);
	assign rcnt_n    = cnt_inc ? (rcnt_q + CNT_W'(1)) : rcnt_q;
	assign step      = cnt_inc && !rcnt_n[0];
	assign hold_load = rev_q
		? ({1'b0, cfg.motion_holdoff} + {1'b0, cfg.reversal_holdoff})
		: {1'b0, cfg.motion_holdoff};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_AX;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	// sequencer: next state and operand selection
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		mac_cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					op_d    = OP_AX;
					state_d = hold_nz ? ST_DONE : ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				mac_cmd.start = 1'b1;
				state_d       = ST_WAIT;
				case (op_q)
					OP_AX: begin
						mac_cmd.clear = 1'b1;
						mac_cmd.x     = OPX_W'(mag_of(a_q[0]));
						mac_cmd.y     = OPY_W'(mag_of(a_q[0]));
					end
					OP_AY: begin
						mac_cmd.x = OPX_W'(mag_of(a_q[1]));
						mac_cmd.y = OPY_W'(mag_of(a_q[1]));
					end
					OP_AZ: begin
						mac_cmd.x = OPX_W'(mag_of(a_q[2]));
						mac_cmd.y = OPY_W'(mag_of(a_q[2]));
					end
					OP_MT: begin
						mac_cmd.clear = 1'b1;
						mac_cmd.x     = OPX_W'(cfg.motion_threshold);
						mac_cmd.y     = OPY_W'(cfg.motion_threshold);
					end
					OP_DX: begin
						mac_cmd.clear = 1'b1;
						mac_cmd.sub   = a_q[0][AX_W-1] ^ r_q[0][AX_W-1];
						mac_cmd.x     = OPX_W'(mag_of(a_q[0]));
						mac_cmd.y     = OPY_W'(mag_of(r_q[0]));
					end
					OP_DY: begin
						mac_cmd.sub = a_q[1][AX_W-1] ^ r_q[1][AX_W-1];
						mac_cmd.x   = OPX_W'(mag_of(a_q[1]));
						mac_cmd.y   = OPY_W'(mag_of(r_q[1]));
					end
					OP_DZ: begin
						mac_cmd.sub = a_q[2][AX_W-1] ^ r_q[2][AX_W-1];
						mac_cmd.x   = OPX_W'(mag_of(a_q[2]));
						mac_cmd.y   = OPY_W'(mag_of(r_q[2]));
					end
					OP_DD: begin
						mac_cmd.clear = 1'b1;
						mac_cmd.x     = OPX_W'(dmag_q);
						mac_cmd.y     = OPY_W'(dmag_q);
					end
					OP_AR: begin
						mac_cmd.clear = 1'b1;
						mac_cmd.x     = OPX_W'(a2_q);
						mac_cmd.y     = OPY_W'(r2_q);
					end
					OP_KQ: begin
						mac_cmd.clear = 1'b1;
						mac_cmd.x     = t_q;
						mac_cmd.y     = KQ_Y;
					end
					OP_PT: begin
						mac_cmd.clear = 1'b1;
						mac_cmd.x     = OPX_W'(cfg.projection_threshold);
						mac_cmd.y     = OPY_W'(cfg.projection_threshold);
					end
					OP_PA: begin
						mac_cmd.clear = 1'b1;
						mac_cmd.x     = OPX_W'(a2_q);
						mac_cmd.y     = t_q[OPY_W-1:0];
					end
					default: mac_cmd.start = 1'b0;
				endcase
			end
			ST_WAIT: begin
				if (!mac_busy) begin
					state_d = ST_ISSUE;
					case (op_q)
						OP_AX: op_d = OP_AY;
						OP_AY: op_d = OP_AZ;
						OP_AZ: op_d = OP_MT;
						OP_MT: begin
							if (motion_now) begin
								op_d = OP_DX;
							end else begin
								state_d = ST_DONE;
							end
						end
						OP_DX: op_d = OP_DY;
						OP_DY: op_d = OP_DZ;
						OP_DZ: begin
							if (dot_neg) begin
								op_d = OP_DD;
							end else begin
								state_d = ST_DONE;
							end
						end
						OP_DD: op_d = OP_AR;
						OP_AR: op_d = OP_KQ;
						OP_KQ: begin
							if (angle_ok) begin
								op_d = OP_PT;
							end else begin
								state_d = ST_DONE;
							end
						end
						OP_PT: op_d = OP_PA;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sample, partial results and per-item flags
	always_ff @(posedge clk) begin
		if (s_fire) begin
			a_q[0]   <= a_in[0];
			a_q[1]   <= a_in[1];
			a_q[2]   <= a_in[2];
			motion_q <= 1'b0;
			loaded_q <= 1'b0;
			rev_q    <= 1'b0;
			held_q   <= hold_nz;
		end
		if (ev) begin
			case (op_q)
				OP_AZ: a2_q <= mac_acc[SQ_W-1:0];
				OP_MT: begin
					motion_q <= motion_now;
					loaded_q <= motion_now && r_zero;
				end
				OP_DZ: dmag_q <= neg_acc[DOT_MAG_W-1:0];
				OP_DD: d2_q   <= mac_acc[D2_W-1:0];
				OP_AR: t_q    <= mac_acc[OPX_W-1:0];
				OP_PT: t_q    <= OPX_W'(mac_acc[2*MAG_W-1:0]);
				OP_PA: rev_q  <= proj_ok;
				default: ;
			endcase
		end
		if (done_fire) begin
			m_data_q <= {2'b00, held_q, loaded_q, step, rev_q, motion_q,
				rcnt_n, rcnt_n[CNT_W-1:1]};
		end
	end

	// reference, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q[0]    <= '0;
			r_q[1]    <= '0;
			r_q[2]    <= '0;
			r2_q      <= '0;
			rcnt_q    <= '0;
			hold_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// first motion sample seeds an empty reference
			if (ev && (op_q == OP_MT) && motion_now && r_zero) begin
				r_q[0] <= a_q[0];
				r_q[1] <= a_q[1];
				r_q[2] <= a_q[2];
				r2_q   <= a2_q;
			end
			if (done_fire) begin
				if (held_q) begin
					hold_q <= hold_q - CNT_W'(1);
				end else if (motion_q) begin
					hold_q <= hold_load;
				end
				if (rev_q) begin
					r_q[0] <= a_q[0];
					r_q[1] <= a_q[1];
					r_q[2] <= a_q[2];
					r2_q   <= a2_q;
				end
				rcnt_q <= rcnt_n;
			end
			if (done_fire) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/accel_reversal_step_detector_top.sv @@
// accept to result word valid: a held-off sample goes straight to the result register, other
// samples first run their products one after another through the shared radix-16
// multiply-accumulate unit, which takes its multiplier one hex digit at a time (4 to 12 products per sample)
// throughput: one sample at a time, the next is accepted once the result is registered
// reset: arst_n clears the reference, counters, holdoff and registers to their defaults
module accel_reversal_step_detector_top
	import arsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// config port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// sample words
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// sample_x, sample_y, sample_z
	input  logic [IN_W-1:0]   s_axis_tdata,
	// result words
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// step_total, reversal_total, motion_seen, reversal_seen, step_done,
	// reference_loaded, held_off, zero pad
	output logic [OUT_W-1:0]  m_axis_tdata
);

	cfg_t             cfg;
	mac_cmd_t         mac_cmd;
	logic             mac_busy;
	logic [MAC_W-1:0] mac_acc;

	arsd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	arsd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.busy   (mac_busy),
		.acc    (mac_acc)
	);

	arsd_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mac_cmd       (mac_cmd),
		.mac_busy      (mac_busy),
		.mac_acc       (mac_acc)
	);

endmodule

@@ rtl/core/arsd_sva_checker.sv @@
module arsd_sva_checker
	import arsd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// one sample in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("sample accepted while busy");

	// step total is half the reversal total
	a_step_half: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OB_REV_LO-1:OB_STEP_LO] == m_axis_tdata[OB_MOTION-1:OB_REV_LO+1])
		else $error("step total does not match reversal total");

	// held-off sample carries no other flag
	a_held_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OB_HELD] |-> m_axis_tdata[OB_LOADED:OB_MOTION] == '0)
		else $error("flags set on held-off sample");

	// a step comes only from a motion reversal landing on an even count
	a_step_src: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[OB_STEP] |->
			m_axis_tdata[OB_REVERSAL] && m_axis_tdata[OB_MOTION] && !m_axis_tdata[OB_REV_LO])
		else $error("step without an even reversal");

endmodule

bind accel_reversal_step_detector_top arsd_sva_checker u_arsd_sva_checker (.*);
